// ===== hdl/edge_end_junction_classifier_macros.svh =====
// Assertion macros shared by the classifier RTL.
`ifndef EDGE_END_JUNCTION_CLASSIFIER_MACROS_SVH
`define EDGE_END_JUNCTION_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define EEJC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define EEJC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define EEJC_ASSERT_IMPL(label, ante, cons, msg)
`define EEJC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/eejc_pkg.sv =====
// Types and constants for the end point / junction classifier.
package eejc_pkg;

	localparam int CFG_DATA_W  = 11;
	localparam int CFG_INDEX_W = 1;
	localparam int COORD_W     = 10;
	localparam int KIND_W      = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

	localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd480;
	localparam logic [CFG_DATA_W-1:0] HEIGHT_MIN   = 11'd3;
	localparam logic [CFG_DATA_W-1:0] HEIGHT_MAX   = 11'd1024;

	localparam logic [3:0] JUNCTION_CHANGES = 4'd6;
	localparam logic [3:0] END_CHANGES      = 4'd2;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE     = 2'd0,
		KIND_END      = 2'd1,
		KIND_JUNCTION = 2'd2
	} kind_t;

	// centre position of a window that is due for classification
	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               last;
	} pos_t;

endpackage

// ===== hdl/edge_end_junction_classifier.sv =====
// Top level of the skeleton end point / junction classifier.
// Pixels of a binary edge image enter on the s_ channel in raster order, one
// per beat, pixel in s_tdata bit 0. Two registers set the image size through
// cfg_we / cfg_index / cfg_data; any write restarts the frame at the top left.
// Every interior pixel yields one beat on the m_ channel once its bottom-right
// neighbour has arrived: kind in m_tuser, centre column and row in m_tdata,
// m_tlast on the final interior pixel of the frame. Border pixels give none.
// A new pixel is taken every cycle unless stalled; m_tvalid rises once the
// beat that completes its window has passed the window register and then the
// output register. The line stores are one 2-bit RAM of MAX_WIDTH entries,
// read one column ahead of the incoming pixel and written back on the beat.
// Reset clears counters, window and valid flags and loads 640 x 480; the line
// stores are not cleared, as the first two rows of a frame fill them.
// When m_tready is low the result holds and one further result may wait in
// the first stage; s_tready then drops until the output drains.
module edge_end_junction_classifier #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [eejc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [eejc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,  // [0] pixel
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [23:0]                        m_tdata,  // [9:0] col, [19:10] row
	output logic [1:0]                         m_tuser,  // [1:0] kind
	output logic                               m_tlast   // frame_last
);
	import eejc_pkg::*;

	pos_t                 info_s1;
	logic [8:0]           window;
	logic                 take;
	logic [KIND_W-1:0]    kind;
	logic [COORD_W-1:0]   col, row;

	eejc_scan #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix_valid(s_tvalid),
		.pix_ready(s_tready),
		.pix      (s_tdata[0]),
		.take     (take),
		.info_s1  (info_s1),
		.window   (window)
	);

	eejc_classify u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.info_s1  (info_s1),
		.window   (window),
		.take     (take),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_kind (kind),
		.out_col  (col),
		.out_row  (row),
		.out_last (m_tlast)
	);

	assign m_tdata = {4'd0, row, col};
	assign m_tuser = kind;

endmodule

// ===== hdl/eejc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module eejc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/eejc_scan.sv =====
// Raster counters, line stores, 3x3 window and first pipeline stage.
module eejc_scan #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [eejc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [eejc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                pix_valid,
	output logic                                pix_ready,
	input  logic                                pix,
	input  logic                                take,
	output eejc_pkg::pos_t                      info_s1,
	output logic [8:0]                          window
);
	import eejc_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;

	logic [CFG_DATA_W-1:0] width_q, height_q;
	logic [CW-1:0]         col_q, col_nx, lastc;
	logic [COORD_W-1:0]    row_q, row_nx, lastr;
	logic [EW-1:0]         w_clamp;
	logic [CFG_DATA_W-1:0] h_clamp;
	logic [8:0]            window_q, window_nx;
	logic [1:0]            line_rd;
	logic                  acc, emit, is_last;
	logic [CW+COORD_W-1:0] colx;
	logic                  valid_s1;
	logic [COORD_W-1:0]    col_s1, row_s1;
	logic                  last_s1;

	always_comb begin
		w_clamp = EW'(width_q);
		if (w_clamp < EW'(3)) w_clamp = EW'(3);
		if (w_clamp > EW'(MAX_WIDTH)) w_clamp = EW'(MAX_WIDTH);
		h_clamp = height_q;
		if (h_clamp < HEIGHT_MIN) h_clamp = HEIGHT_MIN;
		if (h_clamp > HEIGHT_MAX) h_clamp = HEIGHT_MAX;
		lastc = CW'(w_clamp - EW'(1));
		lastr = COORD_W'(h_clamp - 11'd1);
	end

	assign pix_ready = !valid_s1 || take;
	assign acc       = pix_valid && pix_ready;

	always_comb begin
		col_nx = col_q;
		row_nx = row_q;
		if (cfg_we) begin
			col_nx = '0;
			row_nx = '0;
		end else if (acc) begin
			if (col_q == lastc) begin
				col_nx = '0;
				row_nx = (row_q == lastr) ? '0 : row_q + COORD_W'(1);
			end else begin
				col_nx = col_q + CW'(1);
			end
		end
	end

	// entry bit 1: row two above, bit 0: row one above
	eejc_ram #(
		.WIDTH(2),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk  (clk),
		.we   (acc),
		.waddr(col_q),
		.wdata({line_rd[0], pix}),
		.raddr(col_nx),
		.rdata(line_rd)
	);

	assign window_nx = {pix, window_q[8:7], line_rd[0], window_q[5:4], line_rd[1],
		window_q[2:1]};

	assign emit    = (col_q >= CW'(2)) && (row_q >= COORD_W'(2));
	assign is_last = (col_q == lastc) && (row_q == lastr);
	assign colx    = (CW + COORD_W)'(col_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
			window_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
					CFG_IMAGE_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			col_q <= col_nx;
			row_q <= row_nx;
			if (acc) begin
				window_q <= window_nx;
				valid_s1 <= emit;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1  <= colx[COORD_W-1:0];
			row_s1  <= row_q - COORD_W'(1);
			last_s1 <= is_last;
		end
	end

	assign info_s1 = '{valid: valid_s1, col: col_s1, row: row_s1, last: last_s1};
	assign window  = window_q;

	`include "edge_end_junction_classifier_macros.svh"

	`EEJC_ASSERT_NEXT(a_col_wrap, acc && col_q == lastc, col_q == '0, "column did not wrap")
	`EEJC_ASSERT_NEXT(a_emit, acc && emit, valid_s1, "interior pixel lost")
	`EEJC_ASSERT_IMPL(a_pos_range, 1'b1, col_q <= lastc && row_q <= lastr, "position off frame")

endmodule

// ===== hdl/eejc_classify.sv =====
// Crossing-number classifier and output register.
module eejc_classify (
	input  logic                               clk,
	input  logic                               arst_n,
	input  eejc_pkg::pos_t                     info_s1,
	input  logic [8:0]                         window,
	output logic                               take,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [eejc_pkg::KIND_W-1:0]        out_kind,
	output logic [eejc_pkg::COORD_W-1:0]       out_col,
	output logic [eejc_pkg::COORD_W-1:0]       out_row,
	output logic                               out_last
);
	import eejc_pkg::*;

	logic [7:0]         ring, ring_rot;
	logic [3:0]         changes;
	kind_t              kind;
	logic               valid_s2;
	kind_t              kind_s2;
	logic [COORD_W-1:0] col_s2, row_s2;
	logic               last_s2;

	// ring clockwise from top left
	assign ring     = {window[3], window[6], window[7], window[8],
		window[5], window[2], window[1], window[0]};
	assign ring_rot = {ring[6:0], ring[7]};
	assign changes  = 4'($countones(ring ^ ring_rot));

	always_comb begin
		kind = KIND_NONE;
		if (window[4]) begin
			if (changes >= JUNCTION_CHANGES) kind = KIND_JUNCTION;
			else if (changes == END_CHANGES) kind = KIND_END;
		end
	end

	assign take = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= info_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && info_s1.valid) begin
			kind_s2 <= kind;
			col_s2  <= info_s1.col;
			row_s2  <= info_s1.row;
			last_s2 <= info_s1.last;
		end
	end

	assign out_valid = valid_s2;
	assign out_kind  = kind_s2;
	assign out_col   = col_s2;
	assign out_row   = row_s2;
	assign out_last  = last_s2;

	`include "edge_end_junction_classifier_macros.svh"

	`EEJC_ASSERT_NEXT(a_handover, take && info_s1.valid,
		valid_s2 && col_s2 == $past(info_s1.col) && row_s2 == $past(info_s1.row),
		"result not handed to output")
	`EEJC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_col) && $stable(out_row) && $stable(out_kind), "stalled beat changed")
	`EEJC_ASSERT_IMPL(a_kind_legal, out_valid, out_kind <= KIND_JUNCTION, "illegal kind")

endmodule

// ===== bench/edge_end_junction_classifier_test.sv =====
// Self-checking bench for the skeleton end point / junction classifier.
`timescale 1ns / 100ps

module edge_end_junction_classifier_test;
	import eejc_pkg::*;

	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		kind_t              kind;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               last;
	} class_rec_t;

	class junction_tracker_t;
		bit                  row_above2[MAX_COLS];
		bit                  row_above1[MAX_COLS];
		bit [8:0]            window;
		int unsigned         col_pos;
		int unsigned         row_pos;
		logic [CFG_DATA_W-1:0] width_reg;
		logic [CFG_DATA_W-1:0] height_reg;
		class_rec_t          due[$];
		int unsigned         faults;

		function new();
			window = '0;
			col_pos = 0;
			row_pos = 0;
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			faults = 0;
		endfunction

		function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_IMAGE_WIDTH)
				width_reg = val;
			else
				height_reg = val;
			col_pos = 0;
			row_pos = 0;
		endfunction

		function int unsigned pending();
			return due.size();
		endfunction

		// ring walked clockwise from top left; changes = popcount of ring xor its rotation
		function kind_t grade(bit [8:0] win);
			bit [7:0] ring;
			int       changes;
			if (!win[4])
				return KIND_NONE;
			ring = {win[3], win[6], win[7], win[8], win[5], win[2], win[1], win[0]};
			changes = $countones(ring ^ {ring[6:0], ring[7]});
			if (changes >= JUNCTION_CHANGES)
				return KIND_JUNCTION;
			if (changes == END_CHANGES)
				return KIND_END;
			return KIND_NONE;
		endfunction

		function void take_pixel(bit p);
			int unsigned w;
			int unsigned h;
			int unsigned x;
			int unsigned y;
			class_rec_t  rec;
			w = width_reg < 3 ? 3 : (width_reg > MAX_COLS ? MAX_COLS : width_reg);
			h = height_reg < 3 ? 3 : (height_reg > MAX_ROWS ? MAX_ROWS : height_reg);
			x = col_pos;
			y = row_pos;
			window = {p, window[8:7], row_above1[x], window[5:4], row_above2[x], window[2:1]};
			row_above2[x] = row_above1[x];
			row_above1[x] = p;
			if (x >= 2 && y >= 2) begin
				rec.kind = grade(window);
				rec.col = COORD_W'(x - 1);
				rec.row = COORD_W'(y - 1);
				rec.last = (x == w - 1) && (y == h - 1);
				due = {due, rec};
			end
			if (x + 1 >= w) begin
				col_pos = 0;
				row_pos = (y + 1 >= h) ? 0 : y + 1;
			end else begin
				col_pos = x + 1;
			end
		endfunction

		function void match_class(kind_t kind, logic [COORD_W-1:0] col,
				logic [COORD_W-1:0] row, logic last);
			class_rec_t rec;
			if (due.size() == 0) begin
				$error("result with nothing due: kind %0d col %0d row %0d last %0b",
					kind, col, row, last);
				faults++;
				return;
			end
			rec = due.pop_front();
			if (rec.kind !== kind) begin
				$error("kind: expected %0d, got %0d", rec.kind, kind);
				faults++;
			end
			if (rec.col !== col) begin
				$error("col: expected %0d, got %0d", rec.col, col);
				faults++;
			end
			if (rec.row !== row) begin
				$error("row: expected %0d, got %0d", rec.row, row);
				faults++;
			end
			if (rec.last !== last) begin
				$error("frame_last: expected %0b, got %0b", rec.last, last);
				faults++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [23:0]            m_tdata;
	logic [1:0]             m_tuser;
	logic                   m_tlast;

	junction_tracker_t tracker = new();
	int              gap_pct = 9;
	int              stall_pct = 9;
	int unsigned     cycles = 0;

	// directed frames, 4 x 3, first pixel in bit 0
	localparam bit [11:0] JUNCTION_FRAME = 12'b0101_0010_0101;
	localparam bit [11:0] END_FRAME      = 12'b1000_1110_1000;

	edge_end_junction_classifier #(
		.MAX_WIDTH(MAX_COLS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.match_class(kind_t'(m_tuser), m_tdata[9:0], m_tdata[19:10], m_tlast);
	end

	task automatic send_pixel(input bit p, input bit hold);
		if (hold) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while (tracker.pending() != 0)
				@(posedge clk);
		end else begin
			while ($urandom_range(99) < gap_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'($urandom), p};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.take_pixel(p);
	endtask

	task automatic run_pixels(input int count, input int density, input int hold_at);
		for (int i = 0; i < count; i++)
			send_pixel($urandom_range(99) < density, i == hold_at);
		s_tvalid <= 1'b0;
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		tracker.set_register(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// border pixels give no beat, so allow the pipeline to empty past the last one
	task automatic settle();
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		int random_pixels;
		int pick;
		int what;
		int w;
		int h;
		int n;

		random_pixels = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size 640 x 480, no idling on either side;
		// sender holds once mid-stream until all is out
		gap_pct = 0;
		stall_pct = 0;
		run_pixels(1300, 40, 1285);
		settle();
		gap_pct = 9;
		stall_pct = 9;

		write_register(CFG_IMAGE_WIDTH, 11'd4);
		write_register(CFG_IMAGE_HEIGHT, 11'd3);
		for (int i = 0; i < 12; i++)
			send_pixel(JUNCTION_FRAME[i], 1'b0);
		for (int i = 0; i < 12; i++)
			send_pixel(END_FRAME[i], 1'b0);
		s_tvalid <= 1'b0;
		settle();

		while (random_pixels < 420) begin
			pick = $urandom_range(99);
			w = $urandom_range(3, 20);
			h = $urandom_range(3, 12);
			if (pick < 12)
				w = $urandom_range(1) ? $urandom_range(0, 2) : $urandom_range(1024, 2047);
			else if (pick < 24)
				h = $urandom_range(1) ? $urandom_range(0, 2) : $urandom_range(1024, 2047);
			what = $urandom_range(9);
			if (what >= 2) begin
				if (what != 3)
					write_register(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
				if (what != 2)
					write_register(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
			end
			n = $urandom_range(1, 160);
			run_pixels(n, $urandom_range(15, 70), -1);
			random_pixels += n;
			settle();
		end

		if (tracker.faults == 0 && tracker.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
